// ===== src/lbfc_pkg.sv =====
// Shared types, codes and reset values for the LED blink and fade controller.
package lbfc_pkg;

  // Default number of fraction bits in the fixed-point level
  localparam int FRAC_BITS_DEF = 16;

  // Input kinds
  localparam logic [2:0] KIND_STEADY   = 3'd0;
  localparam logic [2:0] KIND_BLINK    = 3'd1;
  localparam logic [2:0] KIND_FADE_IN  = 3'd2;
  localparam logic [2:0] KIND_FADE_OUT = 3'd3;
  localparam logic [2:0] KIND_FADE_IO  = 3'd4;
  localparam logic [2:0] KIND_RESET    = 3'd5;

  // Running effect codes
  localparam logic [2:0] FX_NONE     = 3'd0;
  localparam logic [2:0] FX_BLINK    = 3'd1;
  localparam logic [2:0] FX_FADE_IN  = 3'd2;
  localparam logic [2:0] FX_FADE_OUT = 3'd3;
  localparam logic [2:0] FX_FADE_IO  = 3'd4;

  // Ramp direction codes
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_MIN_LEVEL    = 3'd0;
  localparam logic [2:0] REG_MAX_LEVEL    = 3'd1;
  localparam logic [2:0] REG_COMMON_ANODE = 3'd2;
  localparam logic [2:0] REG_BLINK_PERIOD = 3'd3;
  localparam logic [2:0] REG_FADE_PERIOD  = 3'd4;

  // Register reset values
  localparam logic [7:0]  MIN_LEVEL_RST    = 8'd0;
  localparam logic [7:0]  MAX_LEVEL_RST    = 8'd255;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
  localparam logic [15:0] FADE_PERIOD_RST  = 16'd1000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RAMP,
    ST_FIN
  } st_t;

endpackage

// ===== src/led_blink_fade_controller.sv =====
// LED blink and fade controller: tick sequencer, shared serial divider, config port.
//
// Usage: each beat on the in_ channel is one elapsed-time tick carrying the
// wanted effect (in_kind) and the milliseconds since the last tick
// (in_delta_ms). Every accepted tick produces exactly one beat on the out_
// channel with the driven duty, a write strobe, the activity flag, the
// accumulated active time and the running effect.
// Flow: a tick that only sets a level, blinks, or ends a fade period goes
// from EXEC straight to FIN, and the block takes no new tick until it is
// back in IDLE. A tick that steps a fade runs the ramp increment through
// a restoring divider that retires one quotient bit per cycle over
// FRAC_BITS+24 bits in DIV, then adds it to the level in RAMP before FIN,
// and again the block takes no new tick before it is back in IDLE.
// in_stall is high while a tick is in work. The result sits in an output
// register, so a stalled receiver only holds the block at the end of the
// next tick. Registers are written through the APB-style port (pready always
// high) and should only change while the block is idle.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// effect, the activity counters and the output valid, and sets the duty to 0.
module led_blink_fade_controller
  import lbfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_delta_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_duty,
  output logic        out_duty_written,
  output logic        out_led_active,
  output logic [31:0] out_active_ms,
  output logic [2:0]  out_effect,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = FRAC_BITS + 10;   // level width, signed
  localparam int QW = FRAC_BITS + 24;   // dividend and quotient width
  localparam int SW = QW + 2;           // ramp sum width, signed
  localparam int CW = $clog2(QW + 1);
  localparam logic [CW-1:0] DIV_STEPS = CW'(QW);
  localparam logic signed [SW-1:0] LVL_MAX = {{(SW-LW+1){1'b0}}, {(LW-1){1'b1}}};
  localparam logic signed [SW-1:0] LVL_MIN = {{(SW-LW+1){1'b1}}, {(LW-1){1'b0}}};

  // configuration registers
  logic [7:0]  min_level_r;
  logic [7:0]  max_level_r;
  logic        common_anode_r;
  logic [15:0] blink_period_r;
  logic [15:0] fade_period_r;

  // sequencer and latched tick
  st_t         state_r, state_nxt;
  logic [2:0]  kind_r;
  logic [15:0] delta_r;

  // effect state
  logic [2:0]           effect_mode_r, effect_mode_nxt;
  logic [1:0]           ramp_dir_r, ramp_dir_nxt;
  logic [16:0]          phase_timer_r, phase_timer_nxt;
  logic signed [LW-1:0] level_r, level_nxt;
  logic                 active_flag_r, active_flag_nxt;
  logic [31:0]          active_time_r, active_time_nxt;
  logic [7:0]           duty_r, duty_nxt;
  logic                 wrote_r, wrote_nxt;

  // serial divider
  logic [15:0]   div_rem_r, div_rem_nxt;
  logic [QW-1:0] div_quo_r, div_quo_nxt;
  logic [CW-1:0] div_cnt_r, div_cnt_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_duty_r;
  logic        out_duty_written_r;
  logic        out_led_active_r;
  logic [31:0] out_active_ms_r;
  logic [2:0]  out_effect_r;

  logic cfg_wr;
  logic in_acc;
  logic out_free;

  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // read back registers
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_MIN_LEVEL:    prdata = {24'd0, min_level_r};
      REG_MAX_LEVEL:    prdata = {24'd0, max_level_r};
      REG_COMMON_ANODE: prdata = {31'd0, common_anode_r};
      REG_BLINK_PERIOD: prdata = {16'd0, blink_period_r};
      REG_FADE_PERIOD:  prdata = {16'd0, fade_period_r};
      default:          prdata = '0;
    endcase
  end

  // span of the ramp and its direction
  logic       span_neg;
  logic [7:0] span_mag;
  logic       ramp_up;
  logic [23:0] span_prod;

  assign span_neg  = max_level_r < min_level_r;
  assign span_mag  = span_neg ? (min_level_r - max_level_r) : (max_level_r - min_level_r);
  assign ramp_up   = (ramp_dir_r == DIR_UP) != span_neg;
  assign span_prod = 24'(span_mag) * 24'(delta_r);

  // timer advance and period checks
  logic [16:0] timer_sum;
  logic        blink_expire;
  logic        fade_expire;
  logic        is_fade;
  logic        need_div;

  assign timer_sum    = phase_timer_r + 17'(delta_r);
  assign blink_expire = timer_sum >= {1'b0, blink_period_r};
  assign fade_expire  = timer_sum >= {1'b0, fade_period_r};
  assign is_fade      = (kind_r == KIND_FADE_IN) || (kind_r == KIND_FADE_OUT) ||
                        (kind_r == KIND_FADE_IO);
  assign need_div     = is_fade && (effect_mode_r == kind_r) && !fade_expire;

  // one restoring division step
  logic [16:0] rem_sh;
  logic [16:0] rem_diff;
  logic        rem_ge;

  assign rem_sh   = {div_rem_r, div_quo_r[QW-1]};
  assign rem_ge   = rem_sh >= {1'b0, fade_period_r};
  assign rem_diff = rem_sh - {1'b0, fade_period_r};

  // ramp add with saturation, then duty from the new level
  logic signed [SW-1:0] lvl_ext;
  logic signed [SW-1:0] q_ext;
  logic signed [SW-1:0] lvl_sum;
  logic signed [LW-1:0] lvl_new;
  logic [8:0]           lvl_int;
  logic [7:0]           ramp_duty;
  logic                 ramp_write;

  assign lvl_ext = {{(SW-LW){level_r[LW-1]}}, level_r};
  assign q_ext   = {2'b00, div_quo_r};
  assign lvl_sum = ramp_up ? (lvl_ext + q_ext) : (lvl_ext - q_ext);

  always_comb begin
    if (ramp_dir_r == DIR_ZERO) begin
      lvl_new = level_r;
    end else if (lvl_sum > LVL_MAX) begin
      lvl_new = LVL_MAX[LW-1:0];
    end else if (lvl_sum < LVL_MIN) begin
      lvl_new = LVL_MIN[LW-1:0];
    end else begin
      lvl_new = lvl_sum[LW-1:0];
    end
  end

  assign lvl_int = lvl_new[LW-2:FRAC_BITS];

  always_comb begin
    logic [7:0] d;
    if (lvl_new[LW-1]) begin
      d = 8'd0;
    end else if (lvl_int[8]) begin
      d = 8'hFF;
    end else begin
      d = lvl_int[7:0];
    end
    ramp_duty = common_anode_r ? ~d : d;
  end

  assign ramp_write = (kind_r == KIND_FADE_IO) ||
                      ((kind_r == KIND_FADE_IN) && (ramp_dir_r == DIR_UP)) ||
                      ((kind_r == KIND_FADE_OUT) && (ramp_dir_r == DIR_DOWN));

  // saturating activity sum
  logic [32:0] act_sum;
  assign act_sum = {1'b0, active_time_r} + 33'(delta_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = need_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_cnt_r == CW'(1)) state_nxt = ST_RAMP;
      ST_RAMP: state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // effect datapath
  always_comb begin
    logic [7:0] set_lv;
    logic       do_set;
    logic       do_toggle;
    logic [2:0] enter_fx;
    logic       do_enter;
    logic       start_max;

    effect_mode_nxt = effect_mode_r;
    ramp_dir_nxt    = ramp_dir_r;
    phase_timer_nxt = phase_timer_r;
    level_nxt       = level_r;
    active_flag_nxt = active_flag_r;
    active_time_nxt = active_time_r;
    duty_nxt        = duty_r;
    wrote_nxt       = wrote_r;
    div_rem_nxt     = div_rem_r;
    div_quo_nxt     = div_quo_r;
    div_cnt_nxt     = div_cnt_r;
    set_lv          = max_level_r;
    do_set          = 1'b0;
    do_toggle       = 1'b0;
    enter_fx        = FX_NONE;
    do_enter        = 1'b0;
    start_max       = 1'b0;

    case (state_r)
      ST_EXEC: begin
        wrote_nxt = 1'b0;
        // track activity for every effect kind
        if (kind_r <= KIND_FADE_IO) begin
          if (!active_flag_r) begin
            active_flag_nxt = 1'b1;
          end else begin
            active_time_nxt = act_sum[32] ? 32'hFFFF_FFFF : act_sum[31:0];
          end
        end
        case (kind_r)
          KIND_STEADY: begin
            phase_timer_nxt = '0;
            effect_mode_nxt = FX_NONE;
            ramp_dir_nxt    = DIR_ZERO;
            set_lv          = max_level_r;
            do_set          = 1'b1;
          end
          KIND_BLINK: begin
            if (effect_mode_r != FX_BLINK) begin
              do_enter  = 1'b1;
              enter_fx  = FX_BLINK;
              start_max = 1'b1;
            end else if (blink_expire) begin
              do_toggle = 1'b1;
            end else begin
              phase_timer_nxt = timer_sum;
            end
          end
          KIND_FADE_IN, KIND_FADE_OUT, KIND_FADE_IO: begin
            if (effect_mode_r != kind_r) begin
              do_enter  = 1'b1;
              enter_fx  = kind_r;
              start_max = (kind_r == KIND_FADE_OUT);
            end else if (fade_expire) begin
              do_toggle = 1'b1;
            end else begin
              // load the divider with span * delta scaled to fixed point
              phase_timer_nxt = timer_sum;
              div_rem_nxt     = '0;
              div_quo_nxt     = {span_prod, {FRAC_BITS{1'b0}}};
              div_cnt_nxt     = DIV_STEPS;
            end
          end
          KIND_RESET: begin
            phase_timer_nxt = '0;
            effect_mode_nxt = FX_NONE;
            ramp_dir_nxt    = DIR_ZERO;
            set_lv          = min_level_r;
            do_set          = 1'b1;
            active_time_nxt = '0;
            active_flag_nxt = 1'b0;
          end
          default: ;
        endcase

        // restart an effect at its start level
        if (do_enter) begin
          phase_timer_nxt = '0;
          effect_mode_nxt = enter_fx;
          set_lv          = start_max ? max_level_r : min_level_r;
          do_set          = 1'b1;
          ramp_dir_nxt    = start_max ? DIR_DOWN : DIR_UP;
        end

        // end of period: jump to the far end and turn around
        if (do_toggle) begin
          phase_timer_nxt = '0;
          if (ramp_dir_r == DIR_UP) begin
            set_lv       = max_level_r;
            do_set       = 1'b1;
            ramp_dir_nxt = DIR_DOWN;
          end else if (ramp_dir_r == DIR_DOWN) begin
            set_lv       = min_level_r;
            do_set       = 1'b1;
            ramp_dir_nxt = DIR_UP;
          end
        end

        if (do_set) begin
          level_nxt = {2'b00, set_lv, {FRAC_BITS{1'b0}}};
          duty_nxt  = common_anode_r ? ~set_lv : set_lv;
          wrote_nxt = 1'b1;
        end
      end

      ST_DIV: begin
        div_rem_nxt = rem_ge ? rem_diff[15:0] : rem_sh[15:0];
        div_quo_nxt = {div_quo_r[QW-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r - CW'(1);
      end

      ST_RAMP: begin
        level_nxt = lvl_new;
        if (ramp_write) begin
          duty_nxt  = ramp_duty;
          wrote_nxt = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r        <= MIN_LEVEL_RST;
      max_level_r        <= MAX_LEVEL_RST;
      common_anode_r     <= 1'b0;
      blink_period_r     <= BLINK_PERIOD_RST;
      fade_period_r      <= FADE_PERIOD_RST;
      state_r            <= ST_IDLE;
      effect_mode_r      <= FX_NONE;
      ramp_dir_r         <= DIR_ZERO;
      phase_timer_r      <= '0;
      level_r            <= {2'b00, MIN_LEVEL_RST, {FRAC_BITS{1'b0}}};
      active_flag_r      <= 1'b0;
      active_time_r      <= '0;
      duty_r             <= MIN_LEVEL_RST;
      wrote_r            <= 1'b0;
      div_cnt_r          <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_MIN_LEVEL:    min_level_r    <= pwdata[7:0];
          REG_MAX_LEVEL:    max_level_r    <= pwdata[7:0];
          REG_COMMON_ANODE: common_anode_r <= pwdata[0];
          REG_BLINK_PERIOD: blink_period_r <= pwdata[15:0];
          REG_FADE_PERIOD:  fade_period_r  <= pwdata[15:0];
          default: ;
        endcase
      end
      state_r       <= state_nxt;
      effect_mode_r <= effect_mode_nxt;
      ramp_dir_r    <= ramp_dir_nxt;
      phase_timer_r <= phase_timer_nxt;
      level_r       <= level_nxt;
      active_flag_r <= active_flag_nxt;
      active_time_r <= active_time_nxt;
      duty_r        <= duty_nxt;
      wrote_r       <= wrote_nxt;
      div_cnt_r     <= div_cnt_nxt;
      // drop the result beat once taken, load a new one at the end of a tick
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_kind;
      delta_r <= in_delta_ms;
    end
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    if (state_r == ST_FIN && out_free) begin
      out_duty_r         <= duty_r;
      out_duty_written_r <= wrote_r;
      out_led_active_r   <= active_flag_r;
      out_active_ms_r    <= active_time_r;
      out_effect_r       <= effect_mode_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = out_duty_r;
  assign out_duty_written = out_duty_written_r;
  assign out_led_active   = out_led_active_r;
  assign out_active_ms    = out_active_ms_r;
  assign out_effect       = out_effect_r;

`ifndef SYNTHESIS
  // a result beat only appears at the end of a tick
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result beat raised outside the final step");

  // a running effect always has a ramp direction
  a_effect_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (effect_mode_r != FX_NONE) |-> (ramp_dir_r != DIR_ZERO))
    else $error("effect running without a direction");

  // the divider remainder stays below the fade period
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, div_rem_r} < {1'b0, fade_period_r}))
    else $error("divider remainder out of range");
`endif

endmodule
